// ===== hw/rtl/tsq_pkg.sv =====
// Shared types, constants and helpers of the ternary sign pack quantiser.
package tsq_pkg;

  localparam int unsigned TSQ_BLOCK_ELEMS = 128;
  localparam int unsigned TSQ_QDEPTH      = 4;
  localparam int unsigned TSQ_QCNT_W      = 3;
  localparam int unsigned TSQ_QPTR_W      = 2;

  localparam logic [30:0] TSQ_THRESH_RESET = 31'd897988542;
  localparam logic [30:0] TSQ_INF_MAG      = 31'h7F80_0000;

  localparam logic [1:0] TSQ_CODE_NEG  = 2'd0;
  localparam logic [1:0] TSQ_CODE_ZERO = 2'd1;
  localparam logic [1:0] TSQ_CODE_POS  = 2'd2;

  localparam logic TSQ_KIND_BYTE  = 1'b0;
  localparam logic TSQ_KIND_SCALE = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [31:0] data;
    logic        last;
  } tsq_result_t;

  typedef struct packed {
    logic                  valid;
    logic [TSQ_QCNT_W-1:0] count;
  } tsq_qstat_t;

  function automatic logic [7:0] tsq_place(input logic [1:0] code, input logic [1:0] group);
    logic [7:0] res;
    res = 8'h00;
    case (group)
      2'd0:    res = {code, 6'b0};
      2'd1:    res = {2'b0, code, 4'b0};
      2'd2:    res = {4'b0, code, 2'b0};
      2'd3:    res = {6'b0, code};
      default: res = 8'h00;
    endcase
    return res;
  endfunction

endpackage

// ===== hw/rtl/ternary_sign_pack_quantizer.sv =====
// Top level of the ternary sign pack quantiser: coding, packing memory and result sequencing.
// The block takes one weight per cycle unless stalled. Each weight is coded to two bits and
// merged into a byte of the packing RAM by a read-modify-write over two stages; BLOCK_ELEMS
// must be a multiple of four. When a block completes, its BLOCK_ELEMS/4 bytes are read back
// through the RAM's single read port at one byte per cycle into a four-entry result queue
// while that queue has room. The input stalls after a completing weight until its write stage
// is done and the drain has read the first byte; weights of the next block then enter as fast
// as the drain has read their bytes, which with a free output is one per cycle. After the
// weight marked last, the scale follows the block bytes; a further last or block-completing
// weight waits until that scale is queued. No clearing pass is needed after reset.
module ternary_sign_pack_quantizer import tsq_pkg::*; #(
  parameter int unsigned BLOCK_ELEMS = TSQ_BLOCK_ELEMS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] sample_bits_i,
  input  logic        last_in_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        result_kind_o,
  output logic [31:0] result_data_o,
  output logic        last_out_o,
  input  logic        cfg_we_i,
  input  logic [30:0] cfg_wdata_i
);

  localparam int unsigned PackBytes = BLOCK_ELEMS / 4;
  localparam int unsigned ByteW     = (PackBytes > 1) ? $clog2(PackBytes) : 1;
  localparam int unsigned RdCntW    = $clog2(PackBytes + 1);
  localparam logic [ByteW-1:0]  ByteLast  = ByteW'(PackBytes - 1);
  localparam logic [RdCntW-1:0] RdCntLast = RdCntW'(PackBytes - 1);

  logic [30:0]       thr_q;
  logic [30:0]       max_q, max_d;
  logic [30:0]       scale_q, scale_d;
  logic              scale_pend_q, scale_pend_d;
  logic [ByteW-1:0]  byte_q, byte_d;
  logic [1:0]        group_q, group_d;

  logic              s1_valid_q;
  logic [ByteW-1:0]  s1_addr_q;
  logic [7:0]        s1_bits_q;
  logic              s1_fresh_q;
  logic              s1_done_q;
  logic              s1_last_q;
  logic              fwd_q;
  logic [7:0]        fwd_byte_q;

  logic              drain_active_q, drain_active_d;
  logic [RdCntW-1:0] rd_cnt_q, rd_cnt_d;
  logic              drain_last_q, drain_last_d;
  logic              inflight_q;
  logic              inflight_last_q;

  logic [30:0]       mag;
  logic              is_nan;
  logic [1:0]        code;
  logic [30:0]       new_max;
  logic              completes;
  logic              in_acc;
  logic              drain_go;
  logic              scale_push;
  logic [7:0]        ram_rdata;
  logic [7:0]        old_byte;
  logic [7:0]        new_byte;
  logic [ByteW-1:0]  ram_raddr;

  tsq_qstat_t        q_stat;
  tsq_result_t       q_head;
  tsq_result_t       push_item;
  logic              push;
  logic              pop;

  assign mag       = sample_bits_i[30:0];
  assign is_nan    = mag > TSQ_INF_MAG;
  assign new_max   = (!is_nan && (mag > max_q)) ? mag : max_q;
  assign completes = (group_q == 2'd3) && (byte_q == ByteLast);

  always_comb begin
    if (is_nan) begin
      code = TSQ_CODE_NEG;
    end else if (mag < thr_q) begin
      code = TSQ_CODE_ZERO;
    end else if (!sample_bits_i[31]) begin
      code = TSQ_CODE_POS;
    end else begin
      code = TSQ_CODE_NEG;
    end
  end

  assign in_stall_o = (s1_valid_q && s1_done_q)
                   || (drain_active_q && (rd_cnt_q <= RdCntW'(byte_q)))
                   || (scale_pend_q && (last_in_i || completes));
  assign in_acc     = in_valid_i && !in_stall_o;

  always_comb begin
    byte_d       = byte_q;
    group_d      = group_q;
    max_d        = max_q;
    scale_d      = scale_q;
    scale_pend_d = scale_pend_q && !scale_push;
    if (in_acc) begin
      if (last_in_i || completes) begin
        byte_d  = '0;
        group_d = 2'd0;
      end else if (byte_q == ByteLast) begin
        byte_d  = '0;
        group_d = group_q + 2'd1;
      end else begin
        byte_d = byte_q + 1'b1;
      end
      if (last_in_i) begin
        max_d        = '0;
        scale_d      = new_max;
        scale_pend_d = 1'b1;
      end else begin
        max_d = new_max;
      end
    end
  end

  assign drain_go  = drain_active_q && ((4'(q_stat.count) + 4'(inflight_q)) < 4'(TSQ_QDEPTH));
  assign ram_raddr = drain_go ? rd_cnt_q[ByteW-1:0] : byte_q;

  always_comb begin
    drain_active_d = drain_active_q;
    rd_cnt_d       = rd_cnt_q;
    drain_last_d   = drain_last_q;
    if (s1_valid_q && s1_done_q) begin
      drain_active_d = 1'b1;
      rd_cnt_d       = '0;
      drain_last_d   = !s1_last_q;
    end else if (drain_go) begin
      rd_cnt_d = rd_cnt_q + 1'b1;
      if (rd_cnt_q == RdCntLast) begin
        drain_active_d = 1'b0;
      end
    end
  end

  assign old_byte = fwd_q ? fwd_byte_q : ram_rdata;
  assign new_byte = (s1_fresh_q ? 8'h00 : old_byte) | s1_bits_q;

  tsq_ram #(
    .Width (8),
    .Depth (PackBytes)
  ) u_pack_ram (
    .clk_i   (clk_i),
    .we_i    (s1_valid_q),
    .waddr_i (s1_addr_q),
    .wdata_i (new_byte),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign scale_push = scale_pend_q && !drain_active_q && !inflight_q
                   && !(s1_valid_q && s1_done_q)
                   && (q_stat.count < TSQ_QCNT_W'(TSQ_QDEPTH));

  always_comb begin
    push_item.kind = TSQ_KIND_SCALE;
    push_item.data = {1'b0, scale_q};
    push_item.last = 1'b1;
    if (inflight_q) begin
      push_item.kind = TSQ_KIND_BYTE;
      push_item.data = {24'h0, ram_rdata};
      push_item.last = inflight_last_q;
    end
  end

  assign push = inflight_q || scale_push;
  assign pop  = q_stat.valid && !out_stall_i;

  tsq_outq u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .pop_i       (pop),
    .stat_o      (q_stat),
    .head_o      (q_head)
  );

  assign out_valid_o   = q_stat.valid;
  assign result_kind_o = q_head.kind;
  assign result_data_o = q_head.data;
  assign last_out_o    = q_head.last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q           <= TSQ_THRESH_RESET;
      max_q           <= '0;
      scale_pend_q    <= 1'b0;
      byte_q          <= '0;
      group_q         <= 2'd0;
      s1_valid_q      <= 1'b0;
      drain_active_q  <= 1'b0;
      rd_cnt_q        <= '0;
      drain_last_q    <= 1'b0;
      inflight_q      <= 1'b0;
      inflight_last_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        thr_q <= cfg_wdata_i;
      end
      max_q           <= max_d;
      scale_pend_q    <= scale_pend_d;
      byte_q          <= byte_d;
      group_q         <= group_d;
      s1_valid_q      <= in_acc;
      drain_active_q  <= drain_active_d;
      rd_cnt_q        <= rd_cnt_d;
      drain_last_q    <= drain_last_d;
      inflight_q      <= drain_go;
      inflight_last_q <= drain_go && (rd_cnt_q == RdCntLast) && drain_last_q;
    end
  end

  always_ff @(posedge clk_i) begin
    scale_q <= scale_d;
    if (in_acc) begin
      s1_addr_q  <= byte_q;
      s1_bits_q  <= tsq_place(code, group_q);
      s1_fresh_q <= (group_q == 2'd0);
      s1_done_q  <= completes;
      s1_last_q  <= last_in_i;
      fwd_q      <= s1_valid_q && (s1_addr_q == byte_q);
      fwd_byte_q <= new_byte;
    end
  end

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(drain_go && in_acc && (group_q != 2'd0)))
    else $error("Drain read collided with an item read of the packing RAM.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && s1_done_q) |=> drain_active_q)
    else $error("A completed block did not start its drain.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    scale_push |-> (!drain_active_q && !inflight_q))
    else $error("Scale queued ahead of outstanding block bytes.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> ((q_stat.count < TSQ_QCNT_W'(TSQ_QDEPTH)) || pop))
    else $error("Result queue overflow.");
`endif

endmodule

// ===== hw/rtl/tsq_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
module tsq_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 32,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/tsq_outq.sv =====
// Small result queue that decouples the drain and scale path from the output stall.
module tsq_outq import tsq_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  tsq_result_t push_item_i,
  input  logic        pop_i,
  output tsq_qstat_t  stat_o,
  output tsq_result_t head_o
);

  tsq_result_t           entry_q [TSQ_QDEPTH];
  logic [TSQ_QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [TSQ_QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [TSQ_QCNT_W-1:0] cnt_q, cnt_d;
  logic                  do_pop;

  assign do_pop = pop_i && (cnt_q != '0);

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q + TSQ_QCNT_W'(push_i) - TSQ_QCNT_W'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_item_i;
    end
  end

  assign stat_o.valid = (cnt_q != '0);
  assign stat_o.count = cnt_q;
  assign head_o       = entry_q[rd_ptr_q];

endmodule

// ===== tb/ternary_sign_pack_quantizer_checker.sv =====
// Checker that predicts and compares the results of the ternary sign pack quantiser.
`timescale 1ns / 1ps

module ternary_sign_pack_quantizer_checker import tsq_pkg::*; #(
  parameter int unsigned BLOCK_ELEMS = TSQ_BLOCK_ELEMS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [31:0] sample_bits_i,
  input  logic        last_in_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic        result_kind_i,
  input  logic [31:0] result_data_i,
  input  logic        last_out_i,
  input  logic        cfg_we_i,
  input  logic [30:0] cfg_wdata_i,
  output int          fail_count_o,
  output int          pending_o,
  output int          checked_o
);

  localparam int unsigned PACK_BYTES = BLOCK_ELEMS / 4;

  logic [7:0]  packed_codes [PACK_BYTES];
  int unsigned elem_pos;
  logic [30:0] peak_mag;
  logic [30:0] zero_thresh;
  tsq_result_t expected_results [$];
  int          fail_count;
  int          checked;

  task automatic clear_block();
    for (int i = 0; i < PACK_BYTES; i++) begin
      packed_codes[i] = 8'h00;
    end
    elem_pos = 0;
  endtask

  task automatic quantise_and_pack(input logic [31:0] bits, input logic last_w);
    logic [30:0] mag;
    logic        is_nan;
    logic [1:0]  code;
    int unsigned group;
    int unsigned byte_idx;
    tsq_result_t res;
    mag    = bits[30:0];
    is_nan = mag > TSQ_INF_MAG;
    if (is_nan) begin
      code = TSQ_CODE_NEG;
    end else if (mag < zero_thresh) begin
      code = TSQ_CODE_ZERO;
    end else if (!bits[31]) begin
      code = TSQ_CODE_POS;
    end else begin
      code = TSQ_CODE_NEG;
    end
    if (!is_nan && mag > peak_mag) begin
      peak_mag = mag;
    end
    byte_idx = elem_pos % PACK_BYTES;
    group    = elem_pos / PACK_BYTES;
    packed_codes[byte_idx] = packed_codes[byte_idx] | ({6'b0, code} << (6 - 2 * group));
    if (elem_pos == BLOCK_ELEMS - 1) begin
      for (int i = 0; i < PACK_BYTES; i++) begin
        res.kind = TSQ_KIND_BYTE;
        res.data = {24'h0, packed_codes[i]};
        res.last = (i == PACK_BYTES - 1) && !last_w;
        expected_results.push_back(res);
      end
      clear_block();
    end else begin
      elem_pos++;
    end
    if (last_w) begin
      res.kind = TSQ_KIND_SCALE;
      res.data = {1'b0, peak_mag};
      res.last = 1'b1;
      expected_results.push_back(res);
      clear_block();
      peak_mag = '0;
    end
  endtask

  task automatic report(input string field, input logic [31:0] want, input logic [31:0] got);
    $display("%0t: result %0d %s mismatch, expected %0h, actual %0h",
             $time, checked, field, want, got);
    fail_count++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    tsq_result_t want;
    if (!rst_ni) begin
      clear_block();
      peak_mag    = '0;
      zero_thresh = TSQ_THRESH_RESET;
      expected_results.delete();
      fail_count  = 0;
      checked     = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
      checked_o    <= 0;
    end else begin
      if (in_valid_i && !in_stall_i) begin
        quantise_and_pack(sample_bits_i, last_in_i);
      end
      if (cfg_we_i) begin
        zero_thresh = cfg_wdata_i;
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result, actual kind %0h data %0h last %0h",
                   $time, result_kind_i, result_data_i, last_out_i);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          if (result_kind_i !== want.kind) begin
            report("kind", 32'(want.kind), 32'(result_kind_i));
          end
          if (result_data_i !== want.data) begin
            report("data", want.data, result_data_i);
          end
          if (last_out_i !== want.last) begin
            report("last", 32'(want.last), 32'(last_out_i));
          end
        end
        checked++;
      end
      fail_count_o <= fail_count;
      pending_o    <= expected_results.size();
      checked_o    <= checked;
    end
  end

endmodule

// ===== tb/ternary_sign_pack_quantizer_tb.sv =====
// Top of the ternary sign pack quantiser testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module ternary_sign_pack_quantizer_tb import tsq_pkg::*;;

  localparam int unsigned CYCLE_LIMIT = 300000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [31:0] sample_bits = '0;
  logic        last_in = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        result_kind;
  logic [31:0] result_data;
  logic        last_out;
  logic        cfg_we = 1'b0;
  logic [30:0] cfg_wdata = '0;

  int          fail_count;
  int          pending;
  int          checked;
  int unsigned cycle_count = 0;
  int unsigned weights_sent = 0;
  int unsigned tensors_sent = 0;
  int unsigned thresholds_set = 0;
  int unsigned hold_cycles = 0;
  bit          gaps_on = 1'b1;
  logic [30:0] cur_thresh = TSQ_THRESH_RESET;

  ternary_sign_pack_quantizer i_dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .sample_bits_i (sample_bits),
    .last_in_i     (last_in),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .result_kind_o (result_kind),
    .result_data_o (result_data),
    .last_out_o    (last_out),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (cfg_wdata)
  );

  ternary_sign_pack_quantizer_checker i_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_i    (in_stall),
    .sample_bits_i (sample_bits),
    .last_in_i     (last_in),
    .out_valid_i   (out_valid),
    .out_stall_i   (out_stall),
    .result_kind_i (result_kind),
    .result_data_i (result_data),
    .last_out_i    (last_out),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (cfg_wdata),
    .fail_count_o  (fail_count),
    .pending_o     (pending),
    .checked_o     (checked)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d results outstanding.", cycle_count, pending);
      $display("ternary_sign_pack_quantizer test failed");
      $finish;
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        out_stall <= 1'b1;
        repeat (hold_cycles) @(posedge clk);
        hold_cycles = 0;
        out_stall <= 1'b0;
      end else if (gaps_on && $urandom_range(0, 4) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 7)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  function automatic logic [31:0] rand_weight();
    logic [30:0] mag;
    logic        sgn;
    int unsigned pick;
    sgn  = 1'($urandom_range(0, 1));
    pick = $urandom_range(0, 15);
    case (pick)
      0:       mag = '0;
      1:       mag = {8'hFF, 23'($urandom_range(1, 23'h7FFFFF))};
      2:       mag = TSQ_INF_MAG;
      3:       mag = cur_thresh - 31'd1;
      4:       mag = cur_thresh;
      5:       mag = cur_thresh + 31'd1;
      6:       mag = 31'h7F7F_FFFF;
      7:       mag = 31'($urandom_range(1, 255));
      default: return $urandom();
    endcase
    return {sgn, mag};
  endfunction

  task automatic send_weight(input logic [31:0] bits, input logic last_w);
    in_valid    <= 1'b1;
    sample_bits <= bits;
    last_in     <= last_w;
    do @(posedge clk); while (in_stall);
    weights_sent++;
    if (last_w) begin
      tensors_sent++;
    end
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
  endtask

  task automatic send_tensor(input int unsigned len);
    for (int unsigned i = 0; i < len; i++) begin
      send_weight(rand_weight(), i == len - 1);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_threshold(input logic [30:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    cur_thresh = value;
    thresholds_set++;
  endtask

  initial begin
    logic [31:0] specials [15];
    logic [30:0] phase_thresh [5];
    specials = '{32'h0000_0000, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000,
                 32'h7FC0_0000, 32'hFFFF_FFFF, 32'h7F80_0001, 32'h7F7F_FFFF,
                 32'hFF7F_FFFF, 32'h0000_0001, 32'h3586_37BD, 32'h3586_37BE,
                 32'hB586_37BE, 32'h3F80_0000, 32'hBF80_0000};
    phase_thresh = '{TSQ_THRESH_RESET, 31'h0000_0000, 31'h7FFF_FFFF, 31'h3F80_0000,
                     31'($urandom())};

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // The output is held off long enough for the result queue to fill and stall the input.
    hold_cycles = 600;
    foreach (specials[i]) begin
      send_weight(specials[i], 1'b0);
    end
    for (int i = $size(specials); i < 2 * int'(TSQ_BLOCK_ELEMS); i++) begin
      send_weight(rand_weight(), i == 2 * int'(TSQ_BLOCK_ELEMS) - 1);
    end
    send_weight(32'h1234_5678, 1'b1);
    send_weight(32'h7FC0_0000, 1'b1);
    send_weight(32'h8000_0000, 1'b1);
    wait_drained();

    foreach (phase_thresh[p]) begin
      write_threshold(phase_thresh[p]);
      send_tensor($urandom_range(1, 4));
      wait_drained();
    end

    gaps_on = 1'b0;
    write_threshold(31'($urandom()));
    send_tensor($urandom_range(1, 6));
    send_tensor($urandom_range(1, 6));
    wait_drained();
    repeat (20) @(posedge clk);

    $display("Sent %0d weights in %0d tensors under %0d threshold writes.",
             weights_sent, tensors_sent, thresholds_set);
    $display("Compared %0d results against the prediction, %0d mismatches.",
             checked, fail_count);
    if (fail_count == 0) begin
      $display("ternary_sign_pack_quantizer test passed");
    end else begin
      $display("ternary_sign_pack_quantizer test failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/tsq_pkg.sv
hw/rtl/tsq_ram.sv
hw/rtl/tsq_outq.sv
hw/rtl/ternary_sign_pack_quantizer.sv
tb/ternary_sign_pack_quantizer_checker.sv
tb/ternary_sign_pack_quantizer_tb.sv
